>>> design/stereo_linear_resampler_macros.svh
// Assertion macros for the stereo linear resampler.
`ifndef STEREO_LINEAR_RESAMPLER_MACROS_SVH
`define STEREO_LINEAR_RESAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define SLR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SLR_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SLR_ASSERT(label, clk, rst, prop, msg)
`define SLR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> design/slr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF    = 26;
  localparam int STEP_W           = 32;
  localparam int MAX_RESULTS      = 49;
  localparam int CNT_W            = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic flush;
    logic prime;
    logic load;
    logic mul;
    logic emit;
    logic finish;
  } slr_cmd_t;

  typedef struct packed {
    logic primed;
    logic loop_go;
  } slr_status_t;

endpackage

`default_nettype wire

>>> design/stereo_linear_resampler.sv
// Stereo linear resampler.
// First result valid in the cycle after the item (first frame); otherwise the item passes
// CHECK and EMIT before SEND. Results go one at a time through the multiply/add datapath,
// held in SEND by back-pressure; input waits for the last. Up to 49 results per item.
// Reset (rst, synchronous, active high): step ratio 1.0, no previous frame, phase 0.
`timescale 1ns / 1ps
`default_nettype none

module stereo_linear_resampler #(
  parameter int SAMPLE_WIDTH = slr_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = slr_pkg::FRAC_BITS_DEF,
  parameter int TDATA_W      = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [slr_pkg::STEP_W-1:0] cfg_wdata,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [TDATA_W-1:0]         s_axis_tdata,   // in_left, in_right
  input  logic                       s_axis_tuser,   // op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [TDATA_W-1:0]         m_axis_tdata,   // res_left, res_right
  output logic                       m_axis_tlast    // last
);

  slr_pkg::slr_cmd_t    cmd;
  slr_pkg::slr_status_t st;

  logic signed [SAMPLE_WIDTH-1:0] in_left, in_right;
  logic signed [SAMPLE_WIDTH-1:0] res_left, res_right;

  assign in_left      = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign in_right     = s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign m_axis_tdata = TDATA_W'({res_right, res_left});

  slr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .op      (s_axis_tuser),
    .m_ready (m_axis_tready),
    .st      (st),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .cmd     (cmd)
  );

  slr_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_left   (in_left),
    .in_right  (in_right),
    .cmd       (cmd),
    .st        (st),
    .res_left  (res_left),
    .res_right (res_right),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> design/slr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module slr_datapath #(
  parameter int SAMPLE_WIDTH = slr_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = slr_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [slr_pkg::STEP_W-1:0]          cfg_wdata,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_left,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_right,
  input  slr_pkg::slr_cmd_t                   cmd,
  output slr_pkg::slr_status_t                st,
  output logic signed [SAMPLE_WIDTH-1:0]      res_left,
  output logic signed [SAMPLE_WIDTH-1:0]      res_right,
  output logic                                out_last
);

  localparam int DIFF_W = SAMPLE_WIDTH + 1;
  localparam int WGT_W  = FRAC_BITS + 2;
  localparam int PROD_W = DIFF_W + WGT_W;
  localparam logic [slr_pkg::STEP_W-1:0] ONE = slr_pkg::STEP_W'(1) << FRAC_BITS;
  localparam logic [slr_pkg::CNT_W-1:0]  CNT_MAX = slr_pkg::CNT_W'(slr_pkg::MAX_RESULTS);

  logic [slr_pkg::STEP_W-1:0]     step_ratio;
  logic [slr_pkg::STEP_W-1:0]     phase;
  logic                           primed;
  logic signed [SAMPLE_WIDTH-1:0] prev_left, prev_right;
  logic signed [SAMPLE_WIDTH-1:0] cur_left, cur_right;
  logic signed [DIFF_W-1:0]       diff_left, diff_right;
  logic signed [PROD_W-1:0]       prod_left, prod_right;
  logic [slr_pkg::CNT_W-1:0]      cnt;

  logic                           loop_go;
  logic [slr_pkg::STEP_W:0]       phase_sum;
  logic [slr_pkg::STEP_W-1:0]     phase_sat;
  logic signed [WGT_W-1:0]        weight;
  logic signed [PROD_W-1:0]       q_left, q_right;
  logic signed [DIFF_W-1:0]       sum_left, sum_right;

  assign loop_go   = (phase <= ONE) && (cnt < CNT_MAX);
  assign phase_sum = {1'b0, phase} + {1'b0, step_ratio};
  assign phase_sat = phase_sum[slr_pkg::STEP_W] ? '1 : phase_sum[slr_pkg::STEP_W-1:0];
  assign weight    = $signed({1'b0, phase[FRAC_BITS:0]});

  // arithmetic shift gives the floor
  assign q_left    = prod_left >>> FRAC_BITS;
  assign q_right   = prod_right >>> FRAC_BITS;
  assign sum_left  = $signed({prev_left[SAMPLE_WIDTH-1], prev_left}) + q_left[DIFF_W-1:0];
  assign sum_right = $signed({prev_right[SAMPLE_WIDTH-1], prev_right}) + q_right[DIFF_W-1:0];

  assign st.primed  = primed;
  assign st.loop_go = loop_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio <= ONE;
      primed     <= 1'b0;
      prev_left  <= '0;
      prev_right <= '0;
      phase      <= '0;
    end else begin
      if (cfg_we) begin
        step_ratio <= cfg_wdata;
      end
      if (cmd.flush) begin
        primed     <= 1'b0;
        prev_left  <= '0;
        prev_right <= '0;
        phase      <= '0;
      end
      if (cmd.prime) begin
        primed     <= 1'b1;
        prev_left  <= in_left;
        prev_right <= in_right;
        phase      <= step_ratio;
      end
      if (cmd.mul) begin
        phase <= phase_sat;
      end
      if (cmd.finish) begin
        phase      <= (phase > ONE) ? phase - ONE : '0;
        prev_left  <= cur_left;
        prev_right <= cur_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_left   <= in_left;
      cur_right  <= in_right;
      diff_left  <= $signed({in_left[SAMPLE_WIDTH-1], in_left})
                    - $signed({prev_left[SAMPLE_WIDTH-1], prev_left});
      diff_right <= $signed({in_right[SAMPLE_WIDTH-1], in_right})
                    - $signed({prev_right[SAMPLE_WIDTH-1], prev_right});
      cnt        <= '0;
    end
    if (cmd.mul) begin
      prod_left  <= diff_left * weight;
      prod_right <= diff_right * weight;
      cnt        <= cnt + 1'b1;
    end
    if (cmd.prime) begin
      res_left  <= in_left;
      res_right <= in_right;
      out_last  <= 1'b1;
    end
    if (cmd.emit) begin
      res_left  <= sum_left[SAMPLE_WIDTH-1:0];
      res_right <= sum_right[SAMPLE_WIDTH-1:0];
      out_last  <= ~loop_go;
    end
  end

endmodule

`default_nettype wire

>>> design/slr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_linear_resampler_macros.svh"

module slr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_valid,
  input  logic                 op,
  input  logic                 m_ready,
  input  slr_pkg::slr_status_t st,
  output logic                 s_ready,
  output logic                 m_valid,
  output slr_pkg::slr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    EMIT,
    SEND,
    SEND_PT
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (s_valid && s_ready) begin
          priority if (op) begin
            cmd.flush = 1'b1;
          end else if (!st.primed) begin
            cmd.prime  = 1'b1;
            state_next = SEND_PT;
          end else begin
            cmd.load   = 1'b1;
            state_next = CHECK;
          end
        end
      end
      CHECK: begin
        if (st.loop_go) begin
          cmd.mul    = 1'b1;
          state_next = EMIT;
        end else begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      EMIT: begin
        cmd.emit   = 1'b1;
        state_next = SEND;
      end
      SEND: begin
        if (m_ready) begin
          if (st.loop_go) begin
            cmd.mul    = 1'b1;
            state_next = EMIT;
          end else begin
            cmd.finish = 1'b1;
            state_next = IDLE;
          end
        end
      end
      SEND_PT: begin
        if (m_ready) begin
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      s_ready <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      s_ready <= (state_next == IDLE);
      m_valid <= (state_next == SEND) || (state_next == SEND_PT);
    end
  end

  `SLR_ASSERT(a_no_overlap, clk, rst, !(s_ready && m_valid), "input taken while item pending")
  `SLR_ASSERT(a_mul_go, clk, rst, cmd.mul |-> st.loop_go, "multiply issued past loop end")
  `SLR_ASSERT(a_cmd_onehot, clk, rst,
    $onehot0({cmd.flush, cmd.prime, cmd.load, cmd.mul, cmd.emit, cmd.finish}),
    "more than one command at once")
  `SLR_ASSERT(a_pass_through, clk, rst,
    (s_valid && s_ready && !op && !st.primed) |=> m_valid, "first frame not passed through")

endmodule

`default_nettype wire

>>> sim/stereo_linear_resampler_tb.sv
`timescale 1ns / 1ps

module stereo_linear_resampler_tb;

  localparam int SW     = slr_pkg::SAMPLE_WIDTH_DEF;
  localparam int FB     = slr_pkg::FRAC_BITS_DEF;
  localparam int STEP_W = slr_pkg::STEP_W;
  localparam int TW     = ((2 * SW + 7) / 8) * 8;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [SW-1:0] S_MAX = {1'b0, {(SW - 1){1'b1}}};
  localparam logic [SW-1:0] S_MIN = {1'b1, {(SW - 1){1'b0}}};

  localparam logic [STEP_W-1:0] UNITY   = STEP_W'(1) << FB;
  localparam logic [STEP_W-1:0] STEP_LO = 32'd1398101;
  localparam logic [STEP_W-1:0] STEP_HI = 32'hC000_0000;
  localparam logic [STEP_W-1:0] STEP_CD = 32'd61656268;  // 44.1k -> 48k

  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 36;

  typedef struct packed {
    logic [SW-1:0] left;
    logic [SW-1:0] right;
    logic          last;
  } frame_t;

  typedef enum logic {ROW_ITEM, ROW_STEP} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ECHO} exp_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic              op;
    logic [SW-1:0]     left;
    logic [SW-1:0]     right;
    logic [STEP_W-1:0] step;
    exp_kind_t         want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [STEP_W-1:0] cfg_wdata;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [TW-1:0]     s_axis_tdata;   // in_left, in_right
  logic              s_axis_tuser;   // op
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TW-1:0]     m_axis_tdata;   // res_left, res_right
  logic              m_axis_tlast;   // last

  frame_t frames_due[$];
  row_t   rows[$];
  int     err_count  = 0;
  int     stall_left = 0;
  bit     calm       = 1'b0;

  // predictor state
  logic              primed_q;
  logic [SW-1:0]     hist_left;
  logic [SW-1:0]     hist_right;
  logic [STEP_W-1:0] phase_acc;
  logic [STEP_W-1:0] step_q;

  stereo_linear_resampler u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected item: res_left %0d res_right %0d last %0b",
               $signed(m_axis_tdata[SW-1:0]), $signed(m_axis_tdata[2*SW-1:SW]), m_axis_tlast);
        err_count++;
      end else begin
        want = frames_due.pop_front();
        if (m_axis_tdata[SW-1:0] !== want.left) begin
          $error("res_left expected %0d got %0d",
                 $signed(want.left), $signed(m_axis_tdata[SW-1:0]));
          err_count++;
        end
        if (m_axis_tdata[2*SW-1:SW] !== want.right) begin
          $error("res_right expected %0d got %0d",
                 $signed(want.right), $signed(m_axis_tdata[2*SW-1:SW]));
          err_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last expected %0b got %0b", want.last, m_axis_tlast);
          err_count++;
        end
      end
    end
  end

  // prev + floor((cur - prev) * w / 2^FB)
  function automatic logic [SW-1:0] lerp(input logic [SW-1:0] p, input logic [SW-1:0] c,
                                         input logic [STEP_W-1:0] w);
    longint diff;
    longint prod;
    diff = longint'($signed(c)) - longint'($signed(p));
    prod = diff * longint'(w);
    return SW'(longint'($signed(p)) + (prod >>> FB));
  endfunction

  task automatic predict_item(input logic op, input logic [SW-1:0] cl,
                              input logic [SW-1:0] cr, input bit keep);
    logic [STEP_W:0] sum;
    int              n;
    frame_t          f;
    if (op == OP_FLUSH) begin
      primed_q   = 1'b0;
      hist_left  = '0;
      hist_right = '0;
      phase_acc  = '0;
    end else if (!primed_q) begin
      primed_q   = 1'b1;
      hist_left  = cl;
      hist_right = cr;
      phase_acc  = step_q;
      if (keep) frames_due.push_back('{cl, cr, 1'b1});
    end else begin
      n = 0;
      while (phase_acc <= UNITY && n < slr_pkg::MAX_RESULTS) begin
        f.left  = lerp(hist_left, cl, phase_acc);
        f.right = lerp(hist_right, cr, phase_acc);
        n++;
        sum       = {1'b0, phase_acc} + {1'b0, step_q};
        phase_acc = sum[STEP_W] ? '1 : sum[STEP_W-1:0];
        f.last    = !(phase_acc <= UNITY && n < slr_pkg::MAX_RESULTS);
        if (keep) frames_due.push_back(f);
      end
      phase_acc  = (phase_acc > UNITY) ? phase_acc - UNITY : '0;
      hist_left  = cl;
      hist_right = cr;
    end
  endtask

  task automatic send_item(input logic op, input logic [SW-1:0] l, input logic [SW-1:0] r);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= TW'({r, l});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // hold off the sender until every expected item is out and the block is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_step(input logic [STEP_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    step_q = v;
  endtask

  function automatic logic [SW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      default: return SW'($urandom);
    endcase
  endfunction

  initial begin
    logic          op;
    logic [SW-1:0] l;
    logic [SW-1:0] r;
    logic [STEP_W-1:0] v;

    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_FRAME;

    step_q     = UNITY;
    primed_q   = 1'b0;
    hist_left  = '0;
    hist_right = '0;
    phase_acc  = '0;

    // at unity step every frame comes straight back out
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MAX, S_MIN, '0, EXP_ECHO});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MIN, S_MAX, '0, EXP_ECHO});
    rows.push_back('{ROW_ITEM, OP_FRAME, '0, '1, '0, EXP_ECHO});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MAX, S_MAX, '0, EXP_ECHO});
    rows.push_back('{ROW_ITEM, OP_FLUSH, 24'h00007B, 24'hFFFE38, '0, EXP_NONE});
    rows.push_back('{ROW_ITEM, OP_FRAME, '1, 24'h000001, '0, EXP_ECHO});
    rows.push_back('{ROW_ITEM, OP_FLUSH, S_MAX, S_MIN, '0, EXP_NONE});
    rows.push_back('{ROW_ITEM, OP_FLUSH, '1, '1, '0, EXP_NONE});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MIN, S_MIN, '0, EXP_ECHO});
    rows.push_back('{ROW_STEP, OP_FRAME, '0, '0, UNITY >> 1, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MAX, S_MIN, '0, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MIN, S_MAX, '0, EXP_MODEL});
    rows.push_back('{ROW_STEP, OP_FRAME, '0, '0, STEP_LO, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, '0, '0, '0, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MAX, S_MIN, '0, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MIN, S_MAX, '0, EXP_MODEL});
    rows.push_back('{ROW_STEP, OP_FRAME, '0, '0, STEP_HI, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MAX, S_MAX, '0, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, 24'h000001, '1, '0, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MIN, '0, '0, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MAX, S_MIN, '0, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FLUSH, '0, '0, '0, EXP_NONE});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MAX, S_MIN, '0, EXP_ECHO});
    rows.push_back('{ROW_ITEM, OP_FRAME, S_MIN, S_MAX, '0, EXP_MODEL});
    rows.push_back('{ROW_STEP, OP_FRAME, '0, '0, STEP_CD, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, 24'h123456, 24'hEDCBA9, '0, EXP_MODEL});
    rows.push_back('{ROW_ITEM, OP_FRAME, 24'hA5A5A5, 24'h5A5A5A, '0, EXP_MODEL});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_STEP) begin
        set_step(rows[i].step);
      end else begin
        send_item(rows[i].op, rows[i].left, rows[i].right);
        predict_item(rows[i].op, rows[i].left, rows[i].right, rows[i].want == EXP_MODEL);
        if (rows[i].want == EXP_ECHO) frames_due.push_back('{rows[i].left, rows[i].right, 1'b1});
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       v = STEP_LO;
        1:       v = STEP_HI;
        2:       v = UNITY;
        default: begin
          if ($urandom_range(0, 1) == 0) v = $urandom_range(STEP_LO, UNITY << 1);
          else v = $urandom_range(STEP_LO, STEP_HI);
        end
      endcase
      set_step(v);
      calm = (ph == RAND_PHASES - 1);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = ($urandom_range(0, 19) == 0) ? OP_FLUSH : OP_FRAME;
        l  = pick_sample();
        r  = pick_sample();
        send_item(op, l, r);
        predict_item(op, l, r, 1'b1);
      end
    end

    drain();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/slr_pkg.sv
design/slr_datapath.sv
design/slr_ctrl.sv
design/stereo_linear_resampler.sv
sim/stereo_linear_resampler_tb.sv
